>>> rtl/klcr_pkg.sv
// Shared constants and codes for the line and circle rasterizer.
`default_nettype none
package klcr_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = X_W + Y_W;
  localparam int DIM_W      = 9;

  // Fixed-point walker
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 11;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int L2_W       = 2 * DELTA_W;
  localparam int SQ_IN_W    = L2_W + 16;
  localparam int ROOT_W     = SQ_IN_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int DVD_W      = COORD_W + FRAC_BITS + 8;
  localparam int STEP_W     = FRAC_BITS + 2;
  localparam int WALK_W     = COORD_W + FRAC_BITS + 2;
  localparam int PIX_W      = WALK_W - FRAC_BITS;
  localparam int IT_W       = 6;

  localparam int COLOR_W    = 24;
  localparam int COUNT_W    = 18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Command codes
  localparam logic [1:0] CMD_LINE   = 2'd0;
  localparam logic [1:0] CMD_CIRCLE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PROT   = 2'd2;

endpackage
`default_nettype wire

>>> rtl/keyed_line_circle_raster.sv
// Line and filled-circle rasterizer over a 24-bit RGB frame store.
//
// Usage:
//   Command beat: start_i with the fields, taken when busy_o is low.
//   Result beat: done_o high for one cycle with pixel_color_o,
//   is_protected_o and painted_count_o; the receiver cannot stall.
//   Config beat: cfg_valid_i with cfg_index_i/cfg_data_i; cfg_ready_o is
//   always high. Write registers only while the block is idle.
// Sequencing:
//   Unused command or zero-radius circle: result in the cycle after the beat.
//   Read pixel: result after the generate, address, read and check states.
//   Line: setup including 20 sqrt iterations and 35 divider
//   iterations for both step quotients in parallel, then one point sequence
//   per visited point: ceil(length) points.
//   Circle: one point sequence per point of the 2R by 2R box.
//   Each point is a generate, address, read, check-and-write sequence on
//   the frame memory, which has one read port and one write port.
// Reset:
//   The frame store is cleared to black by a pass over all 65536 entries,
//   one entry a cycle, with busy_o high; config beats are taken meanwhile.
`default_nettype none
module keyed_line_circle_raster (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [1:0]                          command_i,
  input  wire logic signed [klcr_pkg::COORD_W-1:0] start_x_i,
  input  wire logic signed [klcr_pkg::COORD_W-1:0] start_y_i,
  input  wire logic signed [klcr_pkg::COORD_W-1:0] end_x_i,
  input  wire logic signed [klcr_pkg::COORD_W-1:0] end_y_i,
  input  wire logic [7:0]                          radius_i,
  input  wire logic [klcr_pkg::COLOR_W-1:0]        draw_color_i,
  output logic                                     done_o,
  output logic [klcr_pkg::COLOR_W-1:0]             pixel_color_o,
  output logic                                     is_protected_o,
  output logic [klcr_pkg::COUNT_W-1:0]             painted_count_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [klcr_pkg::COLOR_W-1:0]        cfg_data_i
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LSQ  = 4'd2;
  localparam logic [3:0] S_LSUM = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_NSQ  = 4'd5;
  localparam logic [3:0] S_NFIX = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_STEP = 4'd8;
  localparam logic [3:0] S_PGEN = 4'd9;
  localparam logic [3:0] S_PADR = 4'd10;
  localparam logic [3:0] S_PRD  = 4'd11;
  localparam logic [3:0] S_PWR  = 4'd12;

  localparam int AW = klcr_pkg::ADDR_W;
  localparam int CW = klcr_pkg::COLOR_W;
  localparam int DW = klcr_pkg::DIM_W;
  localparam int PW = klcr_pkg::PIX_W;
  localparam int WW = klcr_pkg::WALK_W;
  localparam int FB = klcr_pkg::FRAC_BITS;
  localparam int QW = klcr_pkg::DVD_W;
  localparam int RW = klcr_pkg::ROOT_W;
  localparam int EW = klcr_pkg::REM_W;
  localparam int LW = klcr_pkg::L2_W;
  localparam int TW = klcr_pkg::DELTA_W;
  localparam int SW = klcr_pkg::STEP_W;
  localparam int NW = TW;

  // Truncate a fixed-point walker value toward zero
  function automatic logic signed [PW-1:0] trunc_fn(input logic signed [WW-1:0] p);
    logic [WW-1:0] m;
    m = p[WW-1] ? WW'(-p) : WW'(p);
    trunc_fn = p[WW-1] ? $signed(PW'(-m[WW-1:FB])) : $signed(m[WW-1:FB]);
  endfunction

  logic [3:0]                 state_q;
  logic [AW-1:0]              clr_q;
  logic [DW-1:0]              ww_q, wh_q;
  logic [CW-1:0]              prot_q;
  logic [1:0]                 cmd_q;
  logic signed [klcr_pkg::COORD_W-1:0] sx_q, sy_q;
  logic [7:0]                 rad_q;
  logic [15:0]                r2_q;
  logic [CW-1:0]              col_q;
  logic signed [TW-1:0]       dx_q, dy_q;
  logic [LW-1:0]              sqx_q, sqy_q, l2_q, ssq_q;
  logic [klcr_pkg::SQ_IN_W-1:0] sq_in_q;
  logic [EW-1:0]              srem_q;
  logic [RW-1:0]              root_q;
  logic [klcr_pkg::IT_W-1:0]  it_q;
  logic [NW-1:0]              n_q, i_q;
  logic [QW-1:0]              dvdx_q, dvdy_q, qx_q, qy_q;
  logic [RW-1:0]              remx_q, remy_q;
  logic signed [SW-1:0]       stx_q, sty_q;
  logic signed [WW-1:0]       wkx_q, wky_q;
  logic [DW-1:0]              cw_q, ch_q;
  logic signed [PW-1:0]       px_q, py_q;
  logic [16:0]                sqa_q, sqb_q;
  logic                       ok_q;
  logic [AW-1:0]              addr_q;
  logic [CW-1:0]              rdata_q;
  logic                       done_q;
  logic [CW-1:0]              res_pix_q;
  logic                       res_prot_q;
  logic [klcr_pkg::COUNT_W-1:0] cnt_q;

  logic [DW-1:0]              effw, effh;
  logic [EW-1:0]              srem_t, strial;
  logic [RW:0]                rx_t, ry_t;
  logic [TW-1:0]              s_root;
  logic [16:0]                magx, magy;
  logic signed [9:0]          dxc, dyc;
  logic [DW-1:0]              clast;
  logic                       inwin;
  logic [AW-1:0]              lin;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [CW-1:0]              mem_wd;
  logic [CW-1:0]              mem_q [2**AW];

  assign busy_o          = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign pixel_color_o   = res_pix_q;
  assign is_protected_o  = res_prot_q;
  assign painted_count_o = cnt_q;

  // Effective window limits
  assign effw = (ww_q > DW'(klcr_pkg::MAX_WIDTH))  ? DW'(klcr_pkg::MAX_WIDTH)  : ww_q;
  assign effh = (wh_q > DW'(klcr_pkg::MAX_HEIGHT)) ? DW'(klcr_pkg::MAX_HEIGHT) : wh_q;

  // Square root step, two bits a cycle
  assign srem_t = {srem_q[EW-3:0], sq_in_q[klcr_pkg::SQ_IN_W-1 -: 2]};
  assign strial = {1'b0, root_q, 2'b01};
  assign s_root = root_q[RW-1:8];

  // Divider steps for both axes
  assign rx_t = {remx_q, dvdx_q[QW-1]};
  assign ry_t = {remy_q, dvdy_q[QW-1]};
  assign magx = (qx_q > QW'(2**FB)) ? 17'(2**FB) : qx_q[16:0];
  assign magy = (qy_q > QW'(2**FB)) ? 17'(2**FB) : qy_q[16:0];

  // Circle box offsets
  assign dxc   = $signed({2'b00, rad_q}) - $signed({1'b0, cw_q});
  assign dyc   = $signed({2'b00, rad_q}) - $signed({1'b0, ch_q});
  assign clast = {rad_q, 1'b0} - DW'(1);

  // Window test and linear address
  assign inwin = !px_q[PW-1] && !py_q[PW-1] &&
                 (px_q < $signed({{(PW-DW){1'b0}}, effw})) &&
                 (py_q < $signed({{(PW-DW){1'b0}}, effh}));
  assign lin   = AW'(py_q[klcr_pkg::Y_W-1:0]) * AW'(effw) +
                 AW'(px_q[klcr_pkg::X_W-1:0]);

  // Frame write port: clearing pass or a paint
  assign mem_we = (state_q == S_CLR) ||
                  (state_q == S_PWR && cmd_q != klcr_pkg::CMD_READ && ok_q &&
                   rdata_q != prot_q);
  assign mem_wa = (state_q == S_CLR) ? clr_q : addr_q;
  assign mem_wd = (state_q == S_CLR) ? '0 : col_q;

  // Frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[addr_q];
  end

  // Control and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      ww_q       <= DW'(256);
      wh_q       <= DW'(256);
      prot_q     <= '0;
      done_q     <= 1'b0;
      res_pix_q  <= '0;
      res_prot_q <= 1'b0;
      cnt_q      <= '0;
      cmd_q      <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      rad_q      <= '0;
      r2_q       <= '0;
      col_q      <= '0;
      dx_q       <= '0;
      dy_q       <= '0;
      sqx_q      <= '0;
      sqy_q      <= '0;
      l2_q       <= '0;
      ssq_q      <= '0;
      sq_in_q    <= '0;
      srem_q     <= '0;
      root_q     <= '0;
      it_q       <= '0;
      n_q        <= '0;
      i_q        <= '0;
      dvdx_q     <= '0;
      dvdy_q     <= '0;
      qx_q       <= '0;
      qy_q       <= '0;
      remx_q     <= '0;
      remy_q     <= '0;
      stx_q      <= '0;
      sty_q      <= '0;
      wkx_q      <= '0;
      wky_q      <= '0;
      cw_q       <= '0;
      ch_q       <= '0;
      px_q       <= '0;
      py_q       <= '0;
      sqa_q      <= '0;
      sqb_q      <= '0;
      ok_q       <= 1'b0;
      addr_q     <= '0;
    end else begin
      done_q <= 1'b0;

      // Register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          klcr_pkg::REG_WIDTH:  ww_q   <= cfg_data_i[DW-1:0];
          klcr_pkg::REG_HEIGHT: wh_q   <= cfg_data_i[DW-1:0];
          klcr_pkg::REG_PROT:   prot_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (&clr_q) state_q <= S_IDLE;
        end

        S_IDLE: begin
          if (start_i) begin
            cmd_q      <= command_i;
            sx_q       <= start_x_i;
            sy_q       <= start_y_i;
            rad_q      <= radius_i;
            r2_q       <= radius_i * radius_i;
            col_q      <= draw_color_i;
            dx_q       <= TW'(end_x_i) - TW'(start_x_i);
            dy_q       <= TW'(end_y_i) - TW'(start_y_i);
            cw_q       <= '0;
            ch_q       <= '0;
            cnt_q      <= '0;
            res_pix_q  <= '0;
            res_prot_q <= 1'b0;
            case (command_i)
              klcr_pkg::CMD_LINE: state_q <= S_LSQ;
              klcr_pkg::CMD_CIRCLE: begin
                if (radius_i == 8'd0) done_q  <= 1'b1;
                else                  state_q <= S_PGEN;
              end
              klcr_pkg::CMD_READ: state_q <= S_PGEN;
              default: done_q <= 1'b1;
            endcase
          end
        end

        S_LSQ: begin
          sqx_q <= LW'(dx_q) * LW'(dx_q);
          sqy_q <= LW'(dy_q) * LW'(dy_q);
          state_q <= S_LSUM;
        end

        S_LSUM: begin
          l2_q    <= sqx_q + sqy_q;
          sq_in_q <= {sqx_q + sqy_q, 16'd0};
          srem_q  <= '0;
          root_q  <= '0;
          it_q    <= klcr_pkg::IT_W'(RW);
          if (sqx_q + sqy_q == '0) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SQRT;
          end
        end

        // len8 = floor(sqrt(L2 << 16)), one result bit a cycle
        S_SQRT: begin
          sq_in_q <= sq_in_q << 2;
          if (srem_t >= strial) begin
            srem_q <= srem_t - strial;
            root_q <= {root_q[RW-2:0], 1'b1};
          end else begin
            srem_q <= srem_t;
            root_q <= {root_q[RW-2:0], 1'b0};
          end
          it_q <= it_q - klcr_pkg::IT_W'(1);
          if (it_q == klcr_pkg::IT_W'(1)) state_q <= S_NSQ;
        end

        S_NSQ: begin
          ssq_q   <= LW'(s_root) * LW'(s_root);
          state_q <= S_NFIX;
        end

        S_NFIX: begin
          n_q    <= s_root + NW'(ssq_q < l2_q);
          dvdx_q <= {dx_q[TW-1] ? (TW-1)'(-dx_q) : (TW-1)'(dx_q), (FB + 8)'(0)};
          dvdy_q <= {dy_q[TW-1] ? (TW-1)'(-dy_q) : (TW-1)'(dy_q), (FB + 8)'(0)};
          remx_q <= '0;
          remy_q <= '0;
          qx_q   <= '0;
          qy_q   <= '0;
          it_q   <= klcr_pkg::IT_W'(QW);
          state_q <= S_DIV;
        end

        // Step quotients |d| << 24 / len8, restoring, one bit a cycle
        S_DIV: begin
          dvdx_q <= dvdx_q << 1;
          dvdy_q <= dvdy_q << 1;
          if (rx_t >= {1'b0, root_q}) begin
            remx_q <= RW'(rx_t - {1'b0, root_q});
            qx_q   <= {qx_q[QW-2:0], 1'b1};
          end else begin
            remx_q <= rx_t[RW-1:0];
            qx_q   <= {qx_q[QW-2:0], 1'b0};
          end
          if (ry_t >= {1'b0, root_q}) begin
            remy_q <= RW'(ry_t - {1'b0, root_q});
            qy_q   <= {qy_q[QW-2:0], 1'b1};
          end else begin
            remy_q <= ry_t[RW-1:0];
            qy_q   <= {qy_q[QW-2:0], 1'b0};
          end
          it_q <= it_q - klcr_pkg::IT_W'(1);
          if (it_q == klcr_pkg::IT_W'(1)) state_q <= S_STEP;
        end

        S_STEP: begin
          stx_q <= dx_q[TW-1] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
          sty_q <= dy_q[TW-1] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
          wkx_q <= WW'(sx_q) <<< FB;
          wky_q <= WW'(sy_q) <<< FB;
          i_q   <= '0;
          state_q <= S_PGEN;
        end

        // Point generation
        S_PGEN: begin
          case (cmd_q)
            klcr_pkg::CMD_LINE: begin
              px_q <= trunc_fn(wkx_q);
              py_q <= trunc_fn(wky_q);
            end
            klcr_pkg::CMD_CIRCLE: begin
              px_q  <= PW'(sx_q) + PW'(dxc);
              py_q  <= PW'(sy_q) - PW'(dyc);
              sqa_q <= 17'(dxc) * 17'(dxc);
              sqb_q <= 17'(dyc) * 17'(dyc);
            end
            default: begin
              px_q <= PW'(sx_q);
              py_q <= PW'(sy_q);
            end
          endcase
          state_q <= S_PADR;
        end

        S_PADR: begin
          ok_q <= inwin && (cmd_q != klcr_pkg::CMD_CIRCLE ||
                            (18'(sqa_q) + 18'(sqb_q)) < 18'(r2_q));
          addr_q  <= lin;
          state_q <= S_PRD;
        end

        S_PRD: state_q <= S_PWR;

        // Check, write or deliver the read result, advance
        S_PWR: begin
          state_q <= S_PGEN;
          case (cmd_q)
            klcr_pkg::CMD_LINE: begin
              if (mem_we && cnt_q != klcr_pkg::COUNT_MAX) cnt_q <= cnt_q + 1'b1;
              wkx_q <= wkx_q + WW'(stx_q);
              wky_q <= wky_q + WW'(sty_q);
              i_q   <= i_q + NW'(1);
              if (i_q == n_q - NW'(1)) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end
            klcr_pkg::CMD_CIRCLE: begin
              if (mem_we && cnt_q != klcr_pkg::COUNT_MAX) cnt_q <= cnt_q + 1'b1;
              if (ch_q == clast) begin
                ch_q <= '0;
                cw_q <= cw_q + DW'(1);
                if (cw_q == clast) begin
                  done_q  <= 1'b1;
                  state_q <= S_IDLE;
                end
              end else begin
                ch_q <= ch_q + DW'(1);
              end
            end
            default: begin
              res_pix_q  <= ok_q ? rdata_q : '0;
              res_prot_q <= ok_q && (rdata_q == prot_q);
              done_q     <= 1'b1;
              state_q    <= S_IDLE;
            end
          endcase
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("command beat neither started work nor produced a result");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR || state_q == S_PWR))
    else $error("frame write outside clear or paint");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PWR && mem_we) |=>
      (cnt_q == $past(cnt_q) + 1'b1 || cnt_q == klcr_pkg::COUNT_MAX))
    else $error("painted count missed a write");

  a_read_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cmd_q == klcr_pkg::CMD_READ) |-> (painted_count_o == '0))
    else $error("read result carries a painted count");
`endif

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the keyed line and filled-circle rasterizer.
`timescale 1ns / 100ps

typedef struct {
  logic [1:0]                          cmd;
  logic signed [klcr_pkg::COORD_W-1:0] sx;
  logic signed [klcr_pkg::COORD_W-1:0] sy;
  logic signed [klcr_pkg::COORD_W-1:0] ex;
  logic signed [klcr_pkg::COORD_W-1:0] ey;
  logic [7:0]                          rad;
  logic [klcr_pkg::COLOR_W-1:0]        color;
} draw_cmd_t;

typedef struct {
  logic [klcr_pkg::COLOR_W-1:0] pixel;
  logic                         prot;
  logic [klcr_pkg::COUNT_W-1:0] count;
} draw_res_t;

// Frame-store model plus queue of pending results
class raster_scoreboard;
  logic [klcr_pkg::COLOR_W-1:0] frame [klcr_pkg::MAX_WIDTH*klcr_pkg::MAX_HEIGHT];
  logic [klcr_pkg::DIM_W-1:0]   win_w;
  logic [klcr_pkg::DIM_W-1:0]   win_h;
  logic [klcr_pkg::COLOR_W-1:0] prot_color;
  draw_res_t                    pending[$];
  int                           painted;
  int                           mismatches;

  function new();
    foreach (frame[i]) frame[i] = '0;
    win_w = 256;
    win_h = 256;
    prot_color = '0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [klcr_pkg::COLOR_W-1:0] data);
    if (idx == klcr_pkg::REG_WIDTH) win_w = data[klcr_pkg::DIM_W-1:0];
    else if (idx == klcr_pkg::REG_HEIGHT) win_h = data[klcr_pkg::DIM_W-1:0];
    else if (idx == klcr_pkg::REG_PROT) prot_color = data;
  endfunction

  function longint eff_w();
    return (win_w < klcr_pkg::MAX_WIDTH) ? win_w : klcr_pkg::MAX_WIDTH;
  endfunction

  function longint eff_h();
    return (win_h < klcr_pkg::MAX_HEIGHT) ? win_h : klcr_pkg::MAX_HEIGHT;
  endfunction

  function bit in_window(longint x, longint y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function void plot(longint x, longint y, logic [klcr_pkg::COLOR_W-1:0] c);
    longint a;
    if (!in_window(x, y)) return;
    a = y * eff_w() + x;
    if (frame[a] == prot_color) return;
    frame[a] = c;
    if (painted < klcr_pkg::COUNT_MAX) painted++;
  endfunction

  // Integer square root, digit by digit
  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function longint unit_step(longint d, longint unsigned len8);
    longint unsigned q;
    q = ((d < 0 ? -d : d) << (klcr_pkg::FRAC_BITS + 8)) / len8;
    if (q > (64'd1 << klcr_pkg::FRAC_BITS)) q = 64'd1 << klcr_pkg::FRAC_BITS;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  // DDA walk: ceil(length) points, coordinates truncated toward zero
  function void walk_line(draw_cmd_t c);
    longint x0, y0, dx, dy, px, py, sx, sy;
    longint unsigned l2, n, len8;
    x0 = c.sx;
    y0 = c.sy;
    dx = longint'(c.ex) - x0;
    dy = longint'(c.ey) - y0;
    l2 = dx * dx + dy * dy;
    if (l2 == 0) return;
    n = int_sqrt(l2);
    if (n * n < l2) n++;
    len8 = int_sqrt(l2 << 16);
    sx = unit_step(dx, len8);
    sy = unit_step(dy, len8);
    px = x0 * 65536;
    py = y0 * 65536;
    for (longint unsigned i = 0; i < n; i++) begin
      plot(px / 65536, py / 65536, c.color);
      px += sx;
      py += sy;
    end
  endfunction

  function void fill_circle(draw_cmd_t c);
    longint r, dx, dy;
    r = c.rad;
    for (longint w = 0; w < 2 * r; w++)
      for (longint h = 0; h < 2 * r; h++) begin
        dx = r - w;
        dy = r - h;
        if (dx * dx + dy * dy < r * r) plot(longint'(c.sx) + dx, longint'(c.sy) - dy, c.color);
      end
  endfunction

  // Apply an accepted command beat and queue its result
  function void note_command(draw_cmd_t c);
    draw_res_t r;
    r = '{default: '0};
    painted = 0;
    if (c.cmd == klcr_pkg::CMD_LINE) begin
      walk_line(c);
      r.count = klcr_pkg::COUNT_W'(painted);
    end else if (c.cmd == klcr_pkg::CMD_CIRCLE) begin
      fill_circle(c);
      r.count = klcr_pkg::COUNT_W'(painted);
    end else if (c.cmd == klcr_pkg::CMD_READ && in_window(c.sx, c.sy)) begin
      r.pixel = frame[longint'(c.sy) * eff_w() + longint'(c.sx)];
      r.prot  = (r.pixel == prot_color);
    end
    pending.push_back(r);
  endfunction

  function void check_result(draw_res_t got);
    draw_res_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat: color %h prot %b count %0d",
                                     got.pixel, got.prot, got.count);
      return;
    end
    want = pending.pop_front();
    if (got.pixel !== want.pixel || got.prot !== want.prot || got.count !== want.count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: exp color %h prot %b count %0d, got %h %b %0d",
                 want.pixel, want.prot, want.count, got.pixel, got.prot, got.count);
    end
  endfunction
endclass

module testbench;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int RAND_PER_PHASE = 330;

  logic clk_i, rst_ni;
  logic start_i, busy_o, done_o;
  logic [1:0] command_i;
  logic signed [klcr_pkg::COORD_W-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic [7:0] radius_i;
  logic [klcr_pkg::COLOR_W-1:0] draw_color_i, pixel_color_o;
  logic is_protected_o;
  logic [klcr_pkg::COUNT_W-1:0] painted_count_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [klcr_pkg::COLOR_W-1:0] cfg_data_i;

  raster_scoreboard frame_sb;
  longint cycles;
  logic [klcr_pkg::COLOR_W-1:0] palette [4];

  keyed_line_circle_raster DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    frame_sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    command_i = CMD_NONE;
    start_x_i = '0;
    start_y_i = '0;
    end_x_i = '0;
    end_y_i = '0;
    radius_i = '0;
    draw_color_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = klcr_pkg::REG_WIDTH;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
  initial cycles = 0;

  // Result beats cannot be stalled: check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      frame_sb.check_result('{pixel: pixel_color_o, prot: is_protected_o, count: painted_count_o});
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                                      : $urandom_range(10, 40));
    repeat (n) @(posedge clk_i);
  endtask

  // Valid drops after every config beat, before the next one can begin
  task automatic write_reg(logic [1:0] idx, logic [klcr_pkg::COLOR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    frame_sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    idle_gap();
  endtask

  // Start stays high across back-to-back beats; lowered only before a gap
  task automatic send(draw_cmd_t c);
    int n;
    start_i <= 1'b1;
    command_i <= c.cmd;
    start_x_i <= c.sx;
    start_y_i <= c.sy;
    end_x_i <= c.ex;
    end_y_i <= c.ey;
    radius_i <= c.rad;
    draw_color_i <= c.color;
    do @(posedge clk_i); while (busy_o);
    frame_sb.note_command(c);
    n = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                                      : $urandom_range(10, 40));
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (frame_sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic draw_cmd_t mk(logic [1:0] cmd, int sx, int sy, int ex, int ey, int rad,
                                   logic [klcr_pkg::COLOR_W-1:0] color);
    draw_cmd_t c;
    c.cmd = cmd;
    c.sx = klcr_pkg::COORD_W'(sx);
    c.sy = klcr_pkg::COORD_W'(sy);
    c.ex = klcr_pkg::COORD_W'(ex);
    c.ey = klcr_pkg::COORD_W'(ey);
    c.rad = 8'(rad);
    c.color = color;
    return c;
  endfunction

  function automatic int near_coord();
    return $urandom_range(0, 19) == 0 ? int'($urandom_range(0, 2047)) - 1024
                                      : int'($urandom_range(0, 280)) - 12;
  endfunction

  function automatic logic [klcr_pkg::COLOR_W-1:0] pick_color();
    return $urandom_range(0, 9) < 7 ? palette[$urandom_range(0, 3)]
                                    : klcr_pkg::COLOR_W'($urandom);
  endfunction

  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int sel, sx, sy;
    sel = $urandom_range(0, 99);
    sx = near_coord();
    sy = near_coord();
    c = mk(klcr_pkg::CMD_READ, sx, sy, $urandom, $urandom, $urandom, pick_color());
    if (sel < 35) begin
      c.cmd = klcr_pkg::CMD_LINE;
      // mostly short segments, some across the window, a few across the full range
      if ($urandom_range(0, 19) == 0) begin
        c.ex = klcr_pkg::COORD_W'($urandom);
        c.ey = klcr_pkg::COORD_W'($urandom);
      end else if ($urandom_range(0, 9) == 0) begin
        c.ex = klcr_pkg::COORD_W'(int'($urandom_range(0, 280)) - 12);
        c.ey = klcr_pkg::COORD_W'(int'($urandom_range(0, 280)) - 12);
      end else begin
        c.ex = klcr_pkg::COORD_W'(sx + int'($urandom_range(0, 60)) - 30);
        c.ey = klcr_pkg::COORD_W'(sy + int'($urandom_range(0, 60)) - 30);
      end
    end else if (sel < 60) begin
      c.cmd = klcr_pkg::CMD_CIRCLE;
      c.rad = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 40)) : 8'($urandom_range(0, 12));
    end else if (sel >= 95) begin
      c.cmd = CMD_NONE;
    end
    return c;
  endfunction

  initial begin
    logic [klcr_pkg::COLOR_W-1:0] prot;
    palette[0] = 24'hFF0000;
    palette[1] = 24'h00FF00;
    palette[2] = 24'h0000FF;
    palette[3] = 24'hFFFFFF;
    @(posedge rst_ni);
    @(posedge clk_i);
    // taken during the clearing pass
    write_reg(klcr_pkg::REG_WIDTH, 256);
    write_reg(klcr_pkg::REG_HEIGHT, 256);
    write_reg(klcr_pkg::REG_PROT, 24'h000000);

    // Directed: extremes, every command, protected and out-of-window cases
    send(mk(klcr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send(mk(klcr_pkg::CMD_READ, 255, 255, 0, 0, 0, 0));
    send(mk(klcr_pkg::CMD_LINE, 5, 5, 5, 5, 0, 24'h123456));
    send(mk(klcr_pkg::CMD_LINE, 0, 10, 255, 10, 0, 24'hFF0000));
    send(mk(klcr_pkg::CMD_LINE, 0, 0, 255, 255, 0, 24'hFFFFFF));
    send(mk(klcr_pkg::CMD_LINE, -1024, -1024, 1023, 1023, 0, 24'hAAAAAA));
    send(mk(klcr_pkg::CMD_LINE, 1023, -1024, -1024, 1023, 0, 24'h555555));
    send(mk(klcr_pkg::CMD_LINE, 20, 200, 23, 3, 0, 24'h00FF00));
    send(mk(klcr_pkg::CMD_LINE, -5, 3, 7, -9, 0, 24'h0000FF));
    send(mk(klcr_pkg::CMD_CIRCLE, 50, 50, 0, 0, 0, 24'hFF00FF));
    send(mk(klcr_pkg::CMD_CIRCLE, 50, 50, 0, 0, 1, 24'hFF00FF));
    send(mk(klcr_pkg::CMD_CIRCLE, 0, 0, 0, 0, 6, 24'h00FFFF));
    send(mk(klcr_pkg::CMD_CIRCLE, 128, 128, 0, 0, 255, 24'hFFFFFF));
    send(mk(klcr_pkg::CMD_READ, 128, 128, 0, 0, 0, 0));
    send(mk(klcr_pkg::CMD_READ, -1, 5, 0, 0, 0, 0));
    send(mk(klcr_pkg::CMD_READ, 256, 0, 0, 0, 0, 0));
    send(mk(klcr_pkg::CMD_READ, 1023, -1024, 0, 0, 0, 0));
    send(mk(CMD_NONE, 1023, 1023, -1024, -1024, 255, 24'hFFFFFF));
    drain();
    write_reg(klcr_pkg::REG_PROT, 24'hFFFFFF);
    write_reg(REG_NONE, 24'h000001);
    send(mk(klcr_pkg::CMD_LINE, 0, 128, 255, 128, 0, 24'h00FF00));
    send(mk(klcr_pkg::CMD_READ, 10, 128, 0, 0, 0, 0));
    send(mk(klcr_pkg::CMD_CIRCLE, 128, 128, 0, 0, 4, 24'h0000FF));
    drain();

    // Random phases under several window and protection settings
    for (int ph = 0; ph < 6; ph++) begin
      prot = (ph == 1) ? 24'hFFFFFF : (ph == 0) ? 24'h000000 : palette[$urandom_range(0, 3)];
      case (ph)
        0: begin
          write_reg(klcr_pkg::REG_WIDTH, 256);
          write_reg(klcr_pkg::REG_HEIGHT, 256);
        end
        1: begin
          write_reg(klcr_pkg::REG_WIDTH, 511);
          write_reg(klcr_pkg::REG_HEIGHT, 511);
        end
        2: begin
          write_reg(klcr_pkg::REG_WIDTH, 0);
          write_reg(klcr_pkg::REG_HEIGHT, 10);
        end
        3: begin
          write_reg(klcr_pkg::REG_WIDTH, 1);
          write_reg(klcr_pkg::REG_HEIGHT, 1);
        end
        4: begin
          write_reg(klcr_pkg::REG_WIDTH, 37);
          write_reg(klcr_pkg::REG_HEIGHT, 200);
        end
        default: begin
          write_reg(klcr_pkg::REG_WIDTH, 256);
          write_reg(klcr_pkg::REG_HEIGHT, 3);
        end
      endcase
      write_reg(klcr_pkg::REG_PROT, prot);
      for (int i = 0; i < RAND_PER_PHASE; i++) send(rand_cmd());
      drain();
    end

    if (frame_sb.mismatches == 0 && frame_sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/klcr_pkg.sv
rtl/keyed_line_circle_raster.sv
dv/testbench.sv
